>>> sv/pts_pkg.sv
// Shared package of the packet traffic statistics block: sizes, field codes,
// the input item layout and the control and status bundles.
// Depends on nothing; every other file of the block but pts_ram imports it.
package pts_pkg;

    // Sizes of the counter stores.
    localparam int MAX_LEN          = 9000;
    localparam int PORT_TABLE_DEPTH = 2048;
    localparam int ICMP_TYPES       = 256;
    localparam int HIST_DEPTH       = MAX_LEN + 1;
    localparam int HIST_AW          = $clog2(HIST_DEPTH);
    localparam int PORT_AW          = $clog2(PORT_TABLE_DEPTH);
    localparam int ICMP_AW          = $clog2(ICMP_TYPES);

    // The clearing sweep covers the deepest store.
    localparam int CLR_DEPTH_A = (HIST_DEPTH > PORT_TABLE_DEPTH) ? HIST_DEPTH : PORT_TABLE_DEPTH;
    localparam int CLR_DEPTH   = (CLR_DEPTH_A > ICMP_TYPES) ? CLR_DEPTH_A : ICMP_TYPES;
    localparam int CLR_W       = $clog2(CLR_DEPTH);

    // Field widths.
    localparam int CNT_W   = 64;
    localparam int FUNC_W  = 2;
    localparam int PROTO_W = 2;
    localparam int PORT_W  = 16;
    localparam int ITYPE_W = 8;
    localparam int LEN_W   = 16;
    localparam int TBL_W   = 4;
    localparam int IDX_W   = 14;
    localparam int CFG_W   = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Stream widths: tdata is padded to whole bytes.
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = CNT_W;
    localparam int M_TUSER_W = 1;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Transport kinds.
    localparam logic [PROTO_W-1:0] PROTO_NONE = 2'd0;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 2'd1;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 2'd2;
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 2'd3;

    // Counter set codes for reads.
    localparam logic [TBL_W-1:0] TBL_TOTAL    = 4'd0;
    localparam logic [TBL_W-1:0] TBL_HIST     = 4'd1;
    localparam logic [TBL_W-1:0] TBL_OVERSIZE = 4'd2;
    localparam logic [TBL_W-1:0] TBL_TCP_SRC  = 4'd3;
    localparam logic [TBL_W-1:0] TBL_TCP_DST  = 4'd4;
    localparam logic [TBL_W-1:0] TBL_TCP_HIGH = 4'd5;
    localparam logic [TBL_W-1:0] TBL_UDP_SRC  = 4'd6;
    localparam logic [TBL_W-1:0] TBL_UDP_DST  = 4'd7;
    localparam logic [TBL_W-1:0] TBL_UDP_HIGH = 4'd8;
    localparam logic [TBL_W-1:0] TBL_ICMP     = 4'd9;

    // One input item as held inside the datapath.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               rebuilt;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  src_port;
        logic [PORT_W-1:0]  dst_port;
        logic [ITYPE_W-1:0] icmp_type;
        logic [LEN_W-1:0]   pkt_len;
        logic [TBL_W-1:0]   read_table;
        logic [IDX_W-1:0]   read_index;
    } pts_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
        logic clr_start;
        logic clr_active;
    } pts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_clear;
        logic item_is_read;
        logic clr_done;
    } pts_sts_t;

endpackage

>>> sv/pts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pts_datapath.sv
// Datapath of the packet traffic statistics block: item register, counter
// memories, scalar counters, clearing sweep and the read result register.
// Depends on pts_pkg and pts_ram.
module pts_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pts_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [pts_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [pts_pkg::S_TUSER_W-1:0]  s_tuser,
    input  pts_pkg::pts_cmd_t              cmd,
    output pts_pkg::pts_sts_t              sts,
    output logic [pts_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [pts_pkg::M_TUSER_W-1:0]  m_tuser
);
    import pts_pkg::*;

    pts_item_t          in_item;
    pts_item_t          item_reg;
    pts_item_t          cur;
    logic [CFG_W-1:0]   max_port_reg;
    logic [PORT_W-1:0]  port_lim;
    logic [CLR_W-1:0]   clr_cnt_reg;

    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   oversize_reg;
    logic [CNT_W-1:0]   tcp_high_reg;
    logic [CNT_W-1:0]   udp_high_reg;
    logic [CNT_W-1:0]   count_value_reg;
    logic               read_error_reg;

    logic               cur_upd;
    logic               len_ok;
    logic               s_in;
    logic               d_in;
    logic               hidx_ok;
    logic               pidx_ok;
    logic               iidx_ok;
    logic               do_upd;
    logic [CNT_W-1:0]   len64;

    logic [HIST_AW-1:0] hist_raddr;
    logic [PORT_AW-1:0] src_raddr;
    logic [PORT_AW-1:0] dst_raddr;
    logic [ICMP_AW-1:0] icmp_raddr;
    logic [HIST_AW-1:0] hist_waddr;
    logic [PORT_AW-1:0] src_waddr;
    logic [PORT_AW-1:0] dst_waddr;
    logic [ICMP_AW-1:0] icmp_waddr;
    logic               hist_clr;
    logic               port_clr;
    logic               icmp_clr;

    logic               hist_we;
    logic               tcp_src_we;
    logic               tcp_dst_we;
    logic               udp_src_we;
    logic               udp_dst_we;
    logic               icmp_we;
    logic [CNT_W-1:0]   hist_wdata;
    logic [CNT_W-1:0]   tcp_src_wdata;
    logic [CNT_W-1:0]   tcp_dst_wdata;
    logic [CNT_W-1:0]   udp_src_wdata;
    logic [CNT_W-1:0]   udp_dst_wdata;
    logic [CNT_W-1:0]   icmp_wdata;
    logic [CNT_W-1:0]   hist_rdata;
    logic [CNT_W-1:0]   tcp_src_rdata;
    logic [CNT_W-1:0]   tcp_dst_rdata;
    logic [CNT_W-1:0]   udp_src_rdata;
    logic [CNT_W-1:0]   udp_dst_rdata;
    logic [CNT_W-1:0]   icmp_rdata;

    logic [CNT_W-1:0]   rd_val;
    logic               rd_ok;

    // Unpack the incoming item.
    always_comb
    begin
        in_item.func       = s_tuser;
        in_item.rebuilt    = s_tdata[0];
        in_item.proto      = s_tdata[2:1];
        in_item.src_port   = s_tdata[18:3];
        in_item.dst_port   = s_tdata[34:19];
        in_item.icmp_type  = s_tdata[42:35];
        in_item.pkt_len    = s_tdata[58:43];
        in_item.read_table = s_tdata[62:59];
        in_item.read_index = s_tdata[76:63];
    end

    // The item being accepted drives the read addresses; afterwards the held copy does.
    assign cur = cmd.capture ? in_item : item_reg;

    // Effective tracking limit is capped by the table depth.
    assign port_lim = (32'(max_port_reg) > (PORT_TABLE_DEPTH - 1))
                      ? PORT_W'(PORT_TABLE_DEPTH - 1) : PORT_W'(max_port_reg);

    // Range checks of the current item.
    always_comb
    begin
        cur_upd = (cur.func == FUNC_UPDATE);
        len_ok  = (32'(cur.pkt_len) <= MAX_LEN);
        s_in    = (cur.src_port <= port_lim);
        d_in    = (cur.dst_port <= port_lim);
        hidx_ok = (32'(cur.read_index) <= MAX_LEN);
        pidx_ok = (32'(cur.read_index) < PORT_TABLE_DEPTH);
        iidx_ok = (32'(cur.read_index) < ICMP_TYPES);
        len64   = CNT_W'(cur.pkt_len);
    end

    // Read addresses: packet fields for updates, the read index otherwise.
    always_comb
    begin
        if (cur_upd)
        begin
            hist_raddr = len_ok ? HIST_AW'(cur.pkt_len) : '0;
            src_raddr  = s_in ? PORT_AW'(cur.src_port) : '0;
            dst_raddr  = d_in ? PORT_AW'(cur.dst_port) : '0;
            icmp_raddr = ICMP_AW'(cur.icmp_type);
        end
        else
        begin
            hist_raddr = hidx_ok ? HIST_AW'(cur.read_index) : '0;
            src_raddr  = pidx_ok ? PORT_AW'(cur.read_index) : '0;
            dst_raddr  = pidx_ok ? PORT_AW'(cur.read_index) : '0;
            icmp_raddr = iidx_ok ? ICMP_AW'(cur.read_index) : '0;
        end
    end

    // Clearing sweep covers each store up to its own depth.
    always_comb
    begin
        hist_clr = cmd.clr_active && (32'(clr_cnt_reg) < HIST_DEPTH);
        port_clr = cmd.clr_active && (32'(clr_cnt_reg) < PORT_TABLE_DEPTH);
        icmp_clr = cmd.clr_active && (32'(clr_cnt_reg) < ICMP_TYPES);
        hist_waddr = cmd.clr_active ? HIST_AW'(clr_cnt_reg) : hist_raddr;
        src_waddr  = cmd.clr_active ? PORT_AW'(clr_cnt_reg) : src_raddr;
        dst_waddr  = cmd.clr_active ? PORT_AW'(clr_cnt_reg) : dst_raddr;
        icmp_waddr = cmd.clr_active ? ICMP_AW'(clr_cnt_reg) : icmp_raddr;
    end

    // Read-modify-write of the tables on the commit cycle of an update that is not rebuilt.
    assign do_upd = cmd.commit && cur_upd && !cur.rebuilt;

    always_comb
    begin
        hist_we    = hist_clr || (do_upd && len_ok);
        tcp_src_we = port_clr || (do_upd && (cur.proto == PROTO_TCP) && s_in);
        tcp_dst_we = port_clr || (do_upd && (cur.proto == PROTO_TCP) && d_in);
        udp_src_we = port_clr || (do_upd && (cur.proto == PROTO_UDP) && s_in);
        udp_dst_we = port_clr || (do_upd && (cur.proto == PROTO_UDP) && d_in);
        icmp_we    = icmp_clr || (do_upd && (cur.proto == PROTO_ICMP));
        hist_wdata    = cmd.clr_active ? '0 : hist_rdata + CNT_W'(1);
        tcp_src_wdata = cmd.clr_active ? '0 : tcp_src_rdata + len64;
        tcp_dst_wdata = cmd.clr_active ? '0 : tcp_dst_rdata + len64;
        udp_src_wdata = cmd.clr_active ? '0 : udp_src_rdata + len64;
        udp_dst_wdata = cmd.clr_active ? '0 : udp_dst_rdata + len64;
        icmp_wdata    = cmd.clr_active ? '0 : icmp_rdata + len64;
    end

    // Counter memories.
    pts_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
        .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
        .raddr(hist_raddr), .rdata(hist_rdata)
    );
    pts_ram #(.WIDTH(CNT_W), .DEPTH(PORT_TABLE_DEPTH)) u_tcp_src (
        .clk(clk), .we(tcp_src_we), .waddr(src_waddr), .wdata(tcp_src_wdata),
        .raddr(src_raddr), .rdata(tcp_src_rdata)
    );
    pts_ram #(.WIDTH(CNT_W), .DEPTH(PORT_TABLE_DEPTH)) u_tcp_dst (
        .clk(clk), .we(tcp_dst_we), .waddr(dst_waddr), .wdata(tcp_dst_wdata),
        .raddr(dst_raddr), .rdata(tcp_dst_rdata)
    );
    pts_ram #(.WIDTH(CNT_W), .DEPTH(PORT_TABLE_DEPTH)) u_udp_src (
        .clk(clk), .we(udp_src_we), .waddr(src_waddr), .wdata(udp_src_wdata),
        .raddr(src_raddr), .rdata(udp_src_rdata)
    );
    pts_ram #(.WIDTH(CNT_W), .DEPTH(PORT_TABLE_DEPTH)) u_udp_dst (
        .clk(clk), .we(udp_dst_we), .waddr(dst_waddr), .wdata(udp_dst_wdata),
        .raddr(dst_raddr), .rdata(udp_dst_rdata)
    );
    pts_ram #(.WIDTH(CNT_W), .DEPTH(ICMP_TYPES)) u_icmp (
        .clk(clk), .we(icmp_we), .waddr(icmp_waddr), .wdata(icmp_wdata),
        .raddr(icmp_raddr), .rdata(icmp_rdata)
    );

    // Select the counter named by a read item.
    always_comb
    begin
        rd_val = '0;
        rd_ok  = 1'b0;
        case (cur.read_table)
            TBL_TOTAL:
            begin
                rd_ok  = (cur.read_index == '0);
                rd_val = total_reg;
            end
            TBL_HIST:
            begin
                rd_ok  = hidx_ok;
                rd_val = hist_rdata;
            end
            TBL_OVERSIZE:
            begin
                rd_ok  = (cur.read_index == '0);
                rd_val = oversize_reg;
            end
            TBL_TCP_SRC:
            begin
                rd_ok  = pidx_ok;
                rd_val = tcp_src_rdata;
            end
            TBL_TCP_DST:
            begin
                rd_ok  = pidx_ok;
                rd_val = tcp_dst_rdata;
            end
            TBL_TCP_HIGH:
            begin
                rd_ok  = (cur.read_index == '0);
                rd_val = tcp_high_reg;
            end
            TBL_UDP_SRC:
            begin
                rd_ok  = pidx_ok;
                rd_val = udp_src_rdata;
            end
            TBL_UDP_DST:
            begin
                rd_ok  = pidx_ok;
                rd_val = udp_dst_rdata;
            end
            TBL_UDP_HIGH:
            begin
                rd_ok  = (cur.read_index == '0);
                rd_val = udp_high_reg;
            end
            TBL_ICMP:
            begin
                rd_ok  = iidx_ok;
                rd_val = icmp_rdata;
            end
            default:
            begin
                rd_ok  = 1'b0;
                rd_val = '0;
            end
        endcase
    end

    // Item capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.commit && (cur.func == FUNC_READ))
        begin
            count_value_reg <= rd_ok ? rd_val : '0;
            read_error_reg  <= !rd_ok;
        end
    end

    // Configuration, clearing counter and scalar counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_port_reg <= CFG_RESET;
            clr_cnt_reg  <= '0;
            total_reg    <= '0;
            oversize_reg <= '0;
            tcp_high_reg <= '0;
            udp_high_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_port_reg <= cfg_wdata;
            end
            if (cmd.clr_start)
            begin
                clr_cnt_reg  <= '0;
                total_reg    <= '0;
                oversize_reg <= '0;
                tcp_high_reg <= '0;
                udp_high_reg <= '0;
            end
            else
            begin
                if (cmd.clr_active && !sts.clr_done)
                begin
                    clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                end
                if (do_upd)
                begin
                    total_reg <= total_reg + len64;
                    if (!len_ok)
                    begin
                        oversize_reg <= oversize_reg + CNT_W'(1);
                    end
                    if ((cur.proto == PROTO_TCP) && !s_in && !d_in)
                    begin
                        tcp_high_reg <= tcp_high_reg + len64;
                    end
                    if ((cur.proto == PROTO_UDP) && !s_in && !d_in)
                    begin
                        udp_high_reg <= udp_high_reg + len64;
                    end
                end
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.in_is_clear  = (in_item.func == FUNC_CLEAR);
        sts.item_is_read = (item_reg.func == FUNC_READ);
        sts.clr_done     = (32'(clr_cnt_reg) == (CLR_DEPTH - 1));
    end

    assign m_tdata = count_value_reg;
    assign m_tuser = read_error_reg;

endmodule

>>> sv/pts_ctrl.sv
// Controller of the packet traffic statistics block: clearing sweep, item
// acceptance, commit timing and the result valid flag.
// Depends on pts_pkg.
module pts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  pts_pkg::pts_sts_t sts,
    output pts_pkg::pts_cmd_t cmd
);
    import pts_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   capture;
    logic   commit;

    // An item is taken only in the idle state; a read commits once the result slot is free.
    assign capture = s_tvalid && s_tready_reg;
    assign commit  = (state_reg == ST_EXEC)
                     && (!sts.item_is_read || !m_tvalid_reg || m_tready);

    always_comb
    begin
        cmd.capture    = capture;
        cmd.commit     = commit;
        cmd.clr_start  = capture && sts.in_is_clear;
        cmd.clr_active = (state_reg == ST_CLEAR);
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (commit && sts.item_is_read)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (sts.clr_done)
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (capture)
                    begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= sts.in_is_clear ? ST_CLEAR : ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_CLEAR;
                    s_tready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> sv/packet_traffic_statistics.sv
// Packet traffic statistics: an item is taken only once the previous one is
// done, as the counter RAMs use a registered read-modify-write. A read result
// is registered once the result slot is free and holds until taken; an update
// or clear gives no result. After reset and after a clear item a sweep zeroes
// the RAMs, during which no item is taken (configuration writes still are).
// Depends on pts_pkg, pts_ctrl and pts_datapath.
module packet_traffic_statistics (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pts_pkg::CFG_W-1:0]     cfg_wdata,  // max_tracked_port
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rebuilt, proto, src_port, dst_port, icmp_type, pkt_len, read_table,
    // read_index, zero pad
    input  logic [pts_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [pts_pkg::S_TUSER_W-1:0] s_tuser,    // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pts_pkg::M_TDATA_W-1:0] m_tdata,    // count_value
    output logic [pts_pkg::M_TUSER_W-1:0] m_tuser     // read_error
);
    import pts_pkg::*;

    pts_cmd_t cmd;
    pts_sts_t sts;

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pts_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
